// ===== rtl/bds_pkg.sv =====
// Shared types, constants and helpers for the 2x2 box downsampler.
`default_nettype none
package bds_pkg;

   localparam int CH_W   = 8;   // bits of one color sample
   localparam int SUM_W  = 9;   // bits of a two-sample sum
   localparam int NUM_CH = 4;   // red, green, blue, alpha
   localparam int CFG_W  = 13;  // bits of a geometry register
   localparam int CSR_IDX_W = 1;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // Channel 0 is red, then green, blue, alpha
   typedef logic [NUM_CH-1:0][CH_W-1:0]  pixel_type;
   typedef logic [NUM_CH-1:0][SUM_W-1:0] pair_type;

   // Position decode of the pixel being transferred
   typedef struct packed {
      logic active;   // inside the even-rounded active area
      logic odd_col;
      logic odd_row;
      logic last;     // bottom-right pixel of the last block of the frame
   } pos_ctl_type;

   // Add two pixels channel by channel into 9-bit sums
   function automatic pair_type pair_sum(input pixel_type a, input pixel_type b);
      pair_type r;
      for (int c = 0; c < NUM_CH; c++) begin
         r[c] = {1'b0, a[c]} + {1'b0, b[c]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/bds_pos.sv =====
// Column and row counters with active-area decode for the downsampler.
`default_nettype none
module bds_pos
   import bds_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   localparam int XW = $clog2(MAX_WIDTH),
   localparam int YW = $clog2(MAX_HEIGHT)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CFG_W-1:0] image_width,
   input  wire logic [CFG_W-1:0] image_height,
   input  wire logic             step,
   output pos_ctl_type           ctl,
   output logic [XW-2:0]         slot
);

   localparam int WDW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int HDW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

   logic [XW-1:0]  col_ff, col_in;
   logic [YW-1:0]  row_ff, row_in;
   logic [WDW-1:0] w_cfg, w_use, w_even, x_ext, x_next;
   logic [HDW-1:0] h_cfg, h_use, h_even, y_ext, y_next;

   // Clamp the geometry to MAX_WIDTH and MAX_HEIGHT and round down to even
   always_comb begin
      w_cfg  = WDW'(image_width);
      h_cfg  = HDW'(image_height);
      w_use  = (w_cfg > WDW'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : w_cfg;
      h_use  = (h_cfg > HDW'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : h_cfg;
      w_even = {w_use[WDW-1:1], 1'b0};
      h_even = {h_use[HDW-1:1], 1'b0};
      x_ext  = WDW'(col_ff);
      y_ext  = HDW'(row_ff);
      x_next = x_ext + WDW'(1);
      y_next = y_ext + HDW'(1);
   end

   // Decode the current position
   always_comb begin
      ctl.active  = (x_ext < w_even) && (y_ext < h_even);
      ctl.odd_col = col_ff[0];
      ctl.odd_row = row_ff[0];
      ctl.last    = (x_next == w_even) && (y_next == h_even);
      slot        = col_ff[XW-1:1];
   end

   // Advance the raster position, wrap at the edge of the frame
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (x_next >= w_use) begin
            col_in = '0;
            row_in = (y_next >= h_use) ? '0 : y_next[YW-1:0];
         end else begin
            col_in = x_next[XW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/bds_line.sv =====
// Line store of pair sums from the even row, one write and one registered read port.
`default_nettype none
module bds_line
   import bds_pkg::*;
#(
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire pair_type      wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output pair_type           rd_data
);

   pair_type mem [DEPTH];
   pair_type rd_data_ff;

   // Write the pair sums of the even row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read on demand, hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/bds_avg.sv =====
// Final four-sample average and the result register with its handshake.
`default_nettype none
module bds_avg
   import bds_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire pair_type        top_sum,
   input  wire pair_type        bot_sum,
   input  wire logic            last,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [CH_W-1:0]      rsp_out_red,
   output logic [CH_W-1:0]      rsp_out_green,
   output logic [CH_W-1:0]      rsp_out_blue,
   output logic [CH_W-1:0]      rsp_out_alpha,
   output logic                 rsp_frame_done
);

   logic                 valid_ff, valid_in;
   pixel_type            pix_ff, pix_in;
   logic                 done_ff;
   logic [SUM_W:0]       quad;

   // Sum the top and bottom pairs, drop two bits for the floor average
   always_comb begin
      pix_in = '0;
      quad   = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         quad      = {1'b0, top_sum[c]} + {1'b0, bot_sum[c]};
         pix_in[c] = quad[SUM_W:2];
      end
   end

   assign out_free = !valid_ff || rsp_ready;

   // Hold the result until the transfer, reload behind it
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff  <= pix_in;
         done_ff <= last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_red    = pix_ff[0];
   assign rsp_out_green  = pix_ff[1];
   assign rsp_out_blue   = pix_ff[2];
   assign rsp_out_alpha  = pix_ff[3];
   assign rsp_frame_done = done_ff;

endmodule
`default_nettype wire

// ===== rtl/box_downsample_2x2.sv =====
// Top level of the 2x2 box-filter downsampler for an RGBA pixel stream.
// Pixels enter in raster order, one per cycle when rsp_ready stays high; each aligned
// 2x2 block leaves as one pixel whose channels are the floor of the four-sample average,
// and rsp_frame_done marks the last block of the frame. An odd last column or row is
// dropped. The transfer of a block's bottom-right pixel fills stage one and the
// registered line-store read; the result register takes the average once free. Throughput
// is one pixel per cycle while rsp_ready stays high, set by the single-port read of the
// line store (MAX_WIDTH/2 entries of four 9-bit pair sums) and the result register. The
// line store needs no clearing after reset. Write image_width and image_height only while
// the block is idle; the new geometry applies from the next pixel.
`default_nettype none
module box_downsample_2x2
   import bds_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CH_W-1:0]      req_in_red,
   input  wire logic [CH_W-1:0]      req_in_green,
   input  wire logic [CH_W-1:0]      req_in_blue,
   input  wire logic [CH_W-1:0]      req_in_alpha,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [CH_W-1:0]           rsp_out_red,
   output logic [CH_W-1:0]           rsp_out_green,
   output logic [CH_W-1:0]           rsp_out_blue,
   output logic [CH_W-1:0]           rsp_out_alpha,
   output logic                      rsp_frame_done
);

   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int LINE_DEPTH = MAX_WIDTH / 2;

   logic [CFG_W-1:0] image_width_ff, image_height_ff;
   pos_ctl_type      ctl;
   logic [XW-2:0]    slot;
   logic             req_fire, produce, line_wr, out_free, advance;
   pixel_type        pix, left_ff;
   pair_type         cur_pair, top_sum, bot_ff;
   logic             s1_valid_ff, s1_valid_in, last_ff;

   // Geometry registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CFG_W'(2);
         image_height_ff <= CFG_W'(2);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign pix      = {req_in_alpha, req_in_blue, req_in_green, req_in_red};
   assign req_fire = req_valid && req_ready;

   bds_pos #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pos (
      .clock        (clock),
      .reset        (reset),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .step         (req_fire),
      .ctl          (ctl),
      .slot         (slot)
   );

   // Pair the held even-column pixel with the current one
   assign cur_pair = pair_sum(left_ff, pix);
   assign line_wr  = req_fire && ctl.active && ctl.odd_col && !ctl.odd_row;
   assign produce  = req_fire && ctl.active && ctl.odd_col && ctl.odd_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (req_fire && ctl.active && !ctl.odd_col) begin
         left_ff <= pix;
      end
   end

   bds_line #(
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (slot),
      .wr_data (cur_pair),
      .rd_en   (produce),
      .rd_addr (slot),
      .rd_data (top_sum)
   );

   // Stage one holds the bottom pair while the line store is read
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (produce) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         bot_ff  <= cur_pair;
         last_ff <= ctl.last;
      end
   end

   bds_avg u_avg (
      .clock          (clock),
      .reset          (reset),
      .load           (advance),
      .top_sum        (top_sum),
      .bot_sum        (bot_ff),
      .last           (last_ff),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_alpha  (rsp_out_alpha),
      .rsp_frame_done (rsp_frame_done)
   );

`ifndef SYNTH
   // A full stage one behind a stalled result register blocks new pixels
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("pixel accepted while both stages are full");

   // A bottom-right pixel fills stage one
   a_produce_fills: assert property (@(posedge clock) disable iff (reset)
      produce |=> s1_valid_ff)
      else $error("block result lost on entry to stage one");

   // Stage one moving on shows a result next cycle
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("stage one advanced without a result");

   // Line store is never written and read for the same pixel
   a_one_port_op: assert property (@(posedge clock) disable iff (reset)
      !(line_wr && produce))
      else $error("line store write and read in one transfer");
`endif

endmodule
`default_nettype wire
